// ----- rtl/csw_pkg.sv -----
package csw_pkg;

    localparam int MAX_TERMS     = 8;
    localparam int NUM_TERMS_DEF = 8;

    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 16;
    localparam int CFG_IDX_W = 4;

    // Q.27 accumulator: 32-bit products, up to MAX_TERMS of them
    localparam int ACC_W  = 2 * COEFF_W + $clog2(MAX_TERMS);
    // width of the exact recurrence value 2*x*T(n-1) - T(n-2)*2^15
    localparam int REC_W  = 2 * SAMPLE_W + 2;
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    // T0 = 1.0 in units of 2^-15; needs one bit more than a sample
    localparam logic signed [SAMPLE_W:0] T0_ONE = 17'sd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEFF_W-1:0]  coeff_t;

    // one item as it moves down the term pipeline
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;    // input sample
        logic signed [SAMPLE_W-1:0] t1;   // T(k)
        logic signed [SAMPLE_W:0]   t2;   // T(k-1), wide enough for T0
        logic signed [ACC_W-1:0]    acc;  // sum of products so far
    } csw_item_t;

    // clamp to the signed 16-bit range
    function automatic sample_t sat16(input logic signed [REC_W-1:0] v);
        sample_t r;
        if (v > REC_W'(32767)) begin
            r = 16'sh7FFF;
        end
        else if (v < -REC_W'(32768)) begin
            r = 16'sh8000;
        end
        else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/chebyshev_series_waveshaper.sv -----
// Channel   Direction  Handshake              Payload
// sample    into       sample_valid/_stall    sample_in   (Q1.15)
// shaped    out of     shaped_valid/_stall    shaped_out  (Q4.12)
// cfg       into       cfg_valid/cfg_ready    cfg_index, cfg_data (coeff_1..coeff_N)
//
// There is one register stage per recurrence term, one to add the last
// product and one to round and clamp.
// One sample is taken every clock while nothing stalls; a term stage runs
// the recurrence multiply and the coefficient multiply-add side by side.
// Stalls back up stage by stage: a stage with an empty register keeps loading,
// so bubbles close up while the output is held.
// Reset clears all stage valids and the coefficients; cfg_ready is always high.
module chebyshev_series_waveshaper #(
    parameter int NUM_TERMS = csw_pkg::NUM_TERMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample transactions
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [csw_pkg::SAMPLE_W-1:0] sample_in,
    // result transactions
    output logic                              shaped_valid,
    input  logic                              shaped_stall,
    output logic signed [csw_pkg::SAMPLE_W-1:0] shaped_out,
    // coefficient writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [csw_pkg::COEFF_W-1:0] cfg_data
);
    import csw_pkg::*;

    // coefficient registers; writes to indexes without a term are dropped
    coeff_t                  coeff_reg [NUM_TERMS];

    // link k feeds term stage k+1; link 0 is the raw input
    csw_item_t               link_item  [NUM_TERMS];
    logic                    link_valid [NUM_TERMS];
    logic                    link_ready [NUM_TERMS];

    logic                    sum_valid;
    logic                    sum_ready;
    logic signed [ACC_W-1:0] sum_acc;
    logic                    out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_TERMS; i++) begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg_valid) begin
            for (int i = 0; i < NUM_TERMS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    coeff_reg[i] <= cfg_data;
                end
            end
        end
    end

    // T1 = x, T0 = 1.0, nothing summed yet
    always_comb
    begin
        link_item[0].x   = sample_in;
        link_item[0].t1  = sample_in;
        link_item[0].t2  = T0_ONE;
        link_item[0].acc = '0;
    end
    assign link_valid[0] = sample_valid;
    assign sample_stall  = !link_ready[0];

    // stage k adds coeff_k * T(k) and forms T(k+1)
    for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
        csw_term_stage u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .coeff    (coeff_reg[k-1]),
            .up_valid (link_valid[k-1]),
            .up_ready (link_ready[k-1]),
            .up_item  (link_item[k-1]),
            .dn_valid (link_valid[k]),
            .dn_ready (link_ready[k]),
            .dn_item  (link_item[k])
        );
    end

    csw_sum_stage u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .coeff    (coeff_reg[NUM_TERMS-1]),
        .up_valid (link_valid[NUM_TERMS-1]),
        .up_ready (link_ready[NUM_TERMS-1]),
        .up_item  (link_item[NUM_TERMS-1]),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .dn_acc   (sum_acc)
    );

    assign out_ready = !shaped_stall;

    csw_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .up_acc   (sum_acc),
        .dn_valid (shaped_valid),
        .dn_ready (out_ready),
        .dn_data  (shaped_out)
    );

endmodule

// ----- rtl/csw_term_stage.sv -----
module csw_term_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  csw_pkg::coeff_t    coeff,
    input  logic               up_valid,
    output logic               up_ready,
    input  csw_pkg::csw_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output csw_pkg::csw_item_t dn_item
);
    import csw_pkg::*;

    logic                        valid_reg;
    csw_item_t                   item_reg;
    csw_item_t                   item_next;
    logic signed [2*SAMPLE_W-1:0] xt_prod;
    logic signed [2*COEFF_W-1:0]  ct_prod;
    logic signed [REC_W-1:0]      rec;
    logic signed [REC_W-1:0]      rec_rnd;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    // next term: round(2*x*T(k) - T(k-1)*2^15) to Q1.15, half up, then clamp
    assign xt_prod = up_item.x * up_item.t1;
    assign rec     = (REC_W'(xt_prod) <<< 1) - (REC_W'(up_item.t2) <<< FRAC_SHIFT);
    assign rec_rnd = (rec + REC_W'(ROUND_HALF)) >>> FRAC_SHIFT;

    // product for the current term runs beside the recurrence
    assign ct_prod = coeff * up_item.t1;

    always_comb
    begin
        item_next.x   = up_item.x;
        item_next.t1  = sat16(rec_rnd);
        item_next.t2  = (SAMPLE_W + 1)'(up_item.t1);
        item_next.acc = up_item.acc + ACC_W'(ct_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/csw_sum_stage.sv -----
module csw_sum_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csw_pkg::coeff_t                   coeff,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  csw_pkg::csw_item_t                up_item,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic signed [csw_pkg::ACC_W-1:0]  dn_acc
);
    import csw_pkg::*;

    logic                         valid_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_next;
    logic signed [2*COEFF_W-1:0]  ct_prod;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_acc   = acc_reg;

    // last term's product closes the sum
    assign ct_prod  = coeff * up_item.t1;
    assign acc_next = up_item.acc + ACC_W'(ct_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- rtl/csw_out_stage.sv -----
module csw_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [csw_pkg::ACC_W-1:0]  up_acc,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output csw_pkg::sample_t                  dn_data
);
    import csw_pkg::*;

    localparam int SH_W = ACC_W - FRAC_SHIFT;

    logic                    valid_reg;
    sample_t                 data_reg;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [SH_W-1:0]  acc_sh;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Q.27 -> Q4.12, round half up, clamp
    assign acc_rnd = (up_acc + ACC_W'(ROUND_HALF)) >>> FRAC_SHIFT;
    assign acc_sh  = acc_rnd[SH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            data_reg <= sat16(REC_W'(acc_sh));
        end
    end

endmodule

// ----- tb/sv/tb_chebyshev_series_waveshaper.sv -----
module tb_chebyshev_series_waveshaper;
    timeunit 1ns;
    timeprecision 1ps;

    import csw_pkg::*;

    // Pipeline depth of the block: one stage per term plus round/clamp.
    localparam int TERMS      = NUM_TERMS_DEF;
    localparam int PIPE_DEPTH = TERMS + 1;
    localparam int NUM_IDX    = 1 << CFG_IDX_W;
    // Register index of coeff_1; coeff_n sits at COEFF1_IDX + n - 1.
    localparam int COEFF1_IDX = 0;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [COEFF_W-1:0]  COEFF_MAX  = 16'sh7FFF;
    localparam logic signed [COEFF_W-1:0]  COEFF_MIN  = 16'sh8000;
    localparam logic signed [COEFF_W-1:0]  COEFF_ONE  = 16'sh1000;  // 1.0 in Q4.12

    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 150;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;

    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample_in = '0;

    logic    shaped_valid;
    logic    shaped_stall = 1'b0;
    sample_t shaped_out;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    coeff_t               cfg_data = '0;

    // One expected result, tagged with the sample that produced it.
    typedef struct {
        sample_t x;
        sample_t y;
    } shaped_txn_t;

    shaped_txn_t shaped_expected[$];
    coeff_t      coeff_shadow[MAX_TERMS];   // what the block should hold
    coeff_t      coeff_plan[MAX_TERMS];     // next set to load
    int          fail_count = 0;
    int          gap_pct = 0;               // chance of a sender gap per transaction
    int          stall_pct = 0;             // chance of a receiver stall per cycle
    int          stall_left = 0;

    chebyshev_series_waveshaper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .shaped_valid (shaped_valid),
        .shaped_stall (shaped_stall),
        .shaped_out   (shaped_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: Chebyshev recurrence in Q1.15, products summed exactly
    // in Q.27, result rounded half-up to Q4.12 and clamped.
    // ------------------------------------------------------------------
    function automatic longint round_q15(input longint v);
        // floor((v + 2^14) / 2^15); >>> on a signed longint floors
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic sample_t shape_sample(input sample_t x);
        longint xi;
        longint t_km2;
        longint t_km1;
        longint t_k;
        longint acc;
        xi    = longint'(x);
        t_km2 = 32768;      // T0 = 1.0, used only by the recurrence
        t_km1 = xi;         // T1 = x
        acc   = longint'(coeff_shadow[0]) * xi;
        for (int n = 2; n <= TERMS && n <= MAX_TERMS; n++)
        begin
            // exact 2*x*T(n-1) - T(n-2) in Q.30, then back to Q1.15 with saturation
            t_k   = clamp16(round_q15(2 * xi * t_km1 - t_km2 * 32768));
            acc   = acc + longint'(coeff_shadow[n-1]) * t_k;
            t_km2 = t_km1;
            t_km1 = t_k;
        end
        return sample_t'(clamp16(round_q15(acc)));
    endfunction

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_pause(input int pct);
        if ($urandom_range(99) >= pct)
        begin
            return 0;
        end
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(30, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    // ------------------------------------------------------------------
    // Receiver back-pressure. Runs every cycle; stall_pct = 0 gives a
    // clean stretch with no stalls at all.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = pick_pause(stall_pct);
        end
        shaped_stall <= (stall_left != 0);
        if (stall_left != 0)
        begin
            stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Result checker. Inputs are read at the edge before the block's own
    // updates land, so this sees the pre-edge handshake.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        shaped_txn_t exp_txn;
        if (rst_n && shaped_valid && !shaped_stall)
        begin
            if (shaped_expected.size() == 0)
            begin
                $display("%0t: unexpected shaped transaction, got %0d", $time, shaped_out);
                fail_count++;
            end
            else
            begin
                exp_txn = shaped_expected.pop_front();
                if (shaped_out !== exp_txn.y)
                begin
                    $display("%0t: shaped_out mismatch (sample %0d): expected %0d, got %0d",
                             $time, exp_txn.x, exp_txn.y, shaped_out);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one sample. Valid is left high so back-to-back transactions
    // never drop it; a gap in the next call or drop_sample_valid lowers it.
    task automatic send_sample(input sample_t x);
        shaped_txn_t txn;
        int gap;
        gap = pick_pause(gap_pct);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= x;
        do
        begin
            @(posedge clk);
        end
        while (sample_stall);
        txn.x = x;
        txn.y = shape_sample(x);
        shaped_expected.insert(shaped_expected.size(), txn);
    endtask

    task automatic drop_sample_valid();
        sample_valid <= 1'b0;
        sample_in    <= sample_t'($urandom);
    endtask

    // Sender holds off until every outstanding result is back, then lets
    // the pipeline settle.
    task automatic wait_drained();
        drop_sample_valid();
        @(posedge clk);
        while (shaped_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One register write; cfg_valid stays high until end_cfg.
    task automatic write_reg(input int idx, input coeff_t data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        // writes past the last coefficient are dropped by the block
        if (idx - COEFF1_IDX < MAX_TERMS)
        begin
            coeff_shadow[idx - COEFF1_IDX] = data;
        end
    endtask

    task automatic end_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load coeff_plan into the block; only while idle.
    task automatic load_coeffs();
        wait_drained();
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            write_reg(COEFF1_IDX + i, coeff_plan[i]);
        end
        end_cfg();
    endtask

    function automatic sample_t random_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            return sample_t'($urandom);
        end
        if (sel < 85)
        begin
            case ($urandom_range(4))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                3: return 16'sh0001;
                default: return 16'shFFFF;
            endcase
        end
        return sample_t'($urandom_range(2047)) - 16'sd1024;
    endfunction

    // Coefficient sets of several shapes: full range, gentle, extremes, sparse.
    task automatic plan_random_coeffs(input int shape);
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            case (shape)
                0: coeff_plan[i] = coeff_t'($urandom);
                1: coeff_plan[i] = coeff_t'($urandom_range(8191)) - 16'sd4096;
                2: coeff_plan[i] = $urandom_range(1) ? COEFF_MAX : COEFF_MIN;
                default:
                    coeff_plan[i] = $urandom_range(3) == 0 ? coeff_t'($urandom) : '0;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Coefficients come out of reset as zero, so everything shapes to zero.
    task automatic test_reset_state();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'($urandom));
    endtask

    // Full-scale weights on full-scale samples: drives the term saturation
    // (T2 at x = -1.0 lands on +1.0) and the output clamp both ways.
    task automatic test_corner_values();
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            coeff_plan[i] = COEFF_MAX;
        end
        load_coeffs();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);

        for (int i = 0; i < MAX_TERMS; i++)
        begin
            coeff_plan[i] = COEFF_MIN;
        end
        load_coeffs();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);

        // alternating +/-1.0: odd/even term cancellation around +/-0.5, +/-0.707
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            coeff_plan[i] = (i % 2) ? -COEFF_ONE : COEFF_ONE;
        end
        load_coeffs();
        send_sample(16'sh4000);
        send_sample(16'shC000);
        send_sample(16'sh5A82);
        send_sample(-16'sh5A82);
    endtask

    // Writes to indexes past the last coefficient must leave all weights alone.
    task automatic test_bad_index();
        wait_drained();
        for (int idx = COEFF1_IDX + MAX_TERMS; idx < NUM_IDX; idx++)
        begin
            write_reg(idx, coeff_t'($urandom));
        end
        end_cfg();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sh2000);
        send_sample(sample_t'($urandom));
    endtask

    // Bursts with the sender held off until the pipeline is empty, first
    // at full rate, then against heavy back-pressure.
    task automatic test_drain_pause();
        plan_random_coeffs(1);
        load_coeffs();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (40) send_sample(random_sample());
        wait_drained();
        stall_pct = 70;
        repeat (40) send_sample(random_sample());
        wait_drained();
        stall_pct = 0;
    endtask

    // Many coefficient sets with random samples; idle/stall mix varies per
    // phase, and some phases pause mid-way until all results are back.
    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            plan_random_coeffs(ph % 4);
            load_coeffs();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 20; stall_pct = 20; end
                2: begin gap_pct = 50; stall_pct = 10; end
                default: begin gap_pct = 10; stall_pct = 60; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (ph % 3 == 0 && k == ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                send_sample(random_sample());
            end
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            coeff_shadow[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_corner_values();
        test_bad_index();
        test_drain_pause();
        test_random_phases();

        drop_sample_valid();
        @(posedge clk);
        while (shaped_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // give any stray extra result time to show up
        repeat (4 * PIPE_DEPTH) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("** chebyshev_series_waveshaper: PASSED **");
        end
        else
        begin
            $display("** chebyshev_series_waveshaper: FAILED **");
        end
        $finish;
    end

    // Watchdog: well above the slowest legal run (every transaction taking
    // the longest gap plus the longest stall).
    initial
    begin
        #10ms;
        $display("** chebyshev_series_waveshaper: FAILED **");
        $finish;
    end

endmodule
